@@ design/whp_pkg.sv @@
// package: types, constants and round functions for the whirlpool hash core
package whp_pkg;

  localparam int unsigned Rounds   = 10;
  localparam int unsigned RoundW   = 4;
  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [7:0]  PolyLow  = 8'h1d;

  typedef logic [63:0] word_t;
  typedef word_t [7:0] block_t;

  localparam logic [3:0] BoxE [16] = '{4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
                                       4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0};
  localparam logic [3:0] BoxEi [16] = '{4'hF, 4'h0, 4'hD, 4'h7, 4'hB, 4'hE, 4'h5, 4'hA,
                                        4'h9, 4'h2, 4'hC, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6};
  localparam logic [3:0] BoxR [16] = '{4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
                                       4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};
  localparam logic [3:0] Coef [8] = '{4'd1, 4'd1, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2, 4'd9};

  // compression control between the buffer front end and the round engine
  typedef struct packed {
    logic   start;
    block_t msg;
  } comp_req_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [3:0] u, l, r;
    u = BoxE[x[7:4]];
    l = BoxEi[x[3:0]];
    r = BoxR[u ^ l];
    return {BoxE[u ^ r], BoxEi[l ^ r]};
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? PolyLow : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] c);
    logic [7:0] acc, v;
    acc = 8'h00;
    v = x;
    for (int k = 0; k < 4; k++) begin
      if (c[k]) acc = acc ^ v;
      v = gf_dbl(v);
    end
    return acc;
  endfunction

  function automatic word_t mix_row(input logic [7:0] s);
    word_t row;
    for (int j = 0; j < 8; j++) row[63-8*j -: 8] = gf_mul(s, Coef[j]);
    return row;
  endfunction

  // round constant for round r (1..10)
  function automatic word_t rconst(input logic [RoundW-1:0] r);
    word_t rc;
    logic [7:0] base;
    base = {1'b0, r - 4'd1, 3'b000};
    for (int j = 0; j < 8; j++) rc[63-8*j -: 8] = sbox(base + 8'(j));
    return rc;
  endfunction

endpackage

@@ design/whp_if.sv @@
// valid/ready stream interfaces for input and digest items
interface whp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  byte_count;
  logic        is_last;
  modport source (output valid, message_word, byte_count, is_last, input ready);
  modport sink (input valid, message_word, byte_count, is_last, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ design/whirlpool_hash_core.sv @@
// top level: block buffer, padding, round engine and digest output
// sequence: a block passes through the round engine as start, ten key/state step pairs and hand-back;
// the first digest item shows once the last padding block has come back from the engine.
// throughput: a word a cycle while the buffer is free; it fills the next block while the shared round
// engine works, which bounds sustained input; digest items go out one a cycle when the sink is ready.
// reset: synchronous active-low rst_n clears chaining value, counts and control state.
module whirlpool_hash_core (
  input logic clk,
  input logic rst_n,
  whp_in_if.sink    in_ch,
  whp_out_if.source out_ch
);
  import whp_pkg::*;

  localparam logic [1:0] P_FILL = 2'd0, P_PAD = 2'd1, P_WAIT = 2'd2, P_OUT = 2'd3;

  logic [1:0] ph_r;
  block_t     buf_r, cv_r;
  logic [5:0] cnt_r;
  word_t      bits_r;
  logic       pend_r;          // a full block waits for the engine
  comp_req_t  req;
  logic       busy, done;
  block_t     new_cv;
  logic [2:0] oidx_r;
  logic       oval_r;
  logic       pad2_r;          // padding needs an extra length block
  word_t      spill_r;         // bytes that ran past a full block
  logic [3:0] n;
  logic [6:0] fill;
  block_t     ins;
  word_t      spill;
  block_t     padb;
  word_t      nbits;

  assign n = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
  assign in_ch.ready = (ph_r == P_FILL) && !pend_r;
  assign nbits = bits_r + {57'd0, n, 3'b000};
  assign fill = {1'b0, cnt_r} + {3'b0, n};

  whp_round u_round (.clk(clk), .rst_n(rst_n), .req(req), .cv(cv_r), .busy(busy),
                     .done(done), .new_cv(new_cv));

  assign req.start = pend_r && !busy && !done;
  assign req.msg = buf_r;

  // byte insertion of the incoming word at the current fill position
  always_comb begin
    ins = buf_r;
    for (int b = 0; b < 64; b++) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < n && 7'(b) == {1'b0, cnt_r} + 7'(k))
          ins[b/8][63-8*(b%8) -: 8] = in_ch.message_word[63-8*k -: 8];
      end
    end
  end

  // bytes beyond a full block open the next one
  always_comb begin
    spill = '0;
    for (int m = 0; m < 8; m++) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < n && 7'(64 + m) == {1'b0, cnt_r} + 7'(k))
          spill[63-8*m -: 8] = in_ch.message_word[63-8*k -: 8];
      end
    end
  end

  // first padding block: 0x80 at the fill level, zeros, bit count when it fits
  always_comb begin
    padb = buf_r;
    for (int b = 0; b < 64; b++) begin
      if (7'(b) == {1'b0, cnt_r}) padb[b/8][63-8*(b%8) -: 8] = PadByte;
      else if (7'(b) > {1'b0, cnt_r}) padb[b/8][63-8*(b%8) -: 8] = 8'h00;
    end
    if (!cnt_r[5]) padb[7] = bits_r;
  end

  assign out_ch.valid = oval_r;
  assign out_ch.digest_word = cv_r[oidx_r];
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_FILL;
      cnt_r <= '0;
      bits_r <= '0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
      oidx_r <= '0;
      pad2_r <= 1'b0;
      cv_r <= '0;
    end else begin
      // the engine has taken the block; carried-over bytes move in
      if (req.start) begin
        pend_r <= 1'b0;
        buf_r[0] <= spill_r;
      end
      if (done) cv_r <= new_cv;
      case (ph_r)
        P_FILL: if (in_ch.valid && in_ch.ready) begin
          bits_r <= nbits;
          buf_r <= ins;
          spill_r <= spill;
          cnt_r <= fill[5:0];
          if (fill[6]) pend_r <= 1'b1;
          if (in_ch.is_last) ph_r <= fill[6] ? P_WAIT : P_PAD;
        end
        P_WAIT: if (!pend_r) begin
          // full last block is in flight; pad after the carried-over bytes
          ph_r <= P_PAD;
        end
        P_PAD: if (!pend_r && !busy && !done) begin
          buf_r <= padb;
          pad2_r <= cnt_r[5];
          ph_r <= P_OUT;
          pend_r <= 1'b1;
          cnt_r <= '0;
        end
        P_OUT: begin
          if (pad2_r && !pend_r && !busy && !done) begin
            // second padding block: zeros and the bit count
            buf_r <= {bits_r, 448'd0};
            pend_r <= 1'b1;
            pad2_r <= 1'b0;
          end
          if (done && !pad2_r && !pend_r) oval_r <= 1'b1;
          if (oval_r && out_ch.ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              oval_r <= 1'b0;
              ph_r <= P_FILL;
              cv_r <= '0;
              bits_r <= '0;
              cnt_r <= '0;
            end
          end
        end
        default: ph_r <= P_FILL;
      endcase
    end
  end
endmodule

@@ design/whp_lane.sv @@
// one row lane of the round function: output row i from the eight source rows
module whp_lane (
  input  logic [2:0]     lane_idx,
  input  whp_pkg::block_t src,
  input  whp_pkg::word_t  key,
  output whp_pkg::word_t  row
);
  import whp_pkg::*;

  word_t t [8];
  word_t acc;
  logic [2:0] sel [8];

  // substitute, mix and rotate each contribution, then merge by xor
  always_comb begin
    acc = key;
    for (int j = 0; j < 8; j++) begin
      sel[j] = lane_idx - 3'(j);
      t[j] = mix_row(sbox(src[sel[j]][63-8*j -: 8]));
      if (j != 0) t[j] = (t[j] >> (8*j)) | (t[j] << (64 - 8*j));
      acc = acc ^ t[j];
    end
    row = acc;
  end
endmodule

@@ design/whp_round.sv @@
// round engine: eight lanes for the key schedule and eight for the state
module whp_round (
  input  logic              clk,
  input  logic              rst_n,
  input  whp_pkg::comp_req_t req,
  input  whp_pkg::block_t   cv,
  output logic              busy,
  output logic              done,
  output whp_pkg::block_t   new_cv
);
  import whp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0, S_KEY = 2'd1, S_ST = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [RoundW-1:0] rnd_r, rnd_nxt;
  block_t            k_r, s_r, m_r;
  block_t            k_lane, s_lane;
  word_t             rc;
  logic              done_r;

  assign rc = rconst(rnd_r);

  for (genvar i = 0; i < 8; i++) begin : g_lane
    whp_lane u_k (.lane_idx(3'(i)), .src(k_r), .key(i == 0 ? rc : 64'h0), .row(k_lane[i]));
    whp_lane u_s (.lane_idx(3'(i)), .src(s_r), .key(k_r[i]), .row(s_lane[i]));
  end

  assign busy = (st_r != S_IDLE);
  assign done = done_r;
  assign new_cv = k_r;

  // next state: key step then state step per round
  always_comb begin
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    case (st_r)
      S_IDLE: if (req.start) begin st_nxt = S_KEY; rnd_nxt = RoundW'(1); end
      S_KEY: st_nxt = S_ST;
      S_ST: begin
        if (rnd_r == RoundW'(Rounds)) st_nxt = S_IDLE;
        else begin st_nxt = S_KEY; rnd_nxt = rnd_r + RoundW'(1); end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      rnd_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rnd_r <= rnd_nxt;
      done_r <= (st_r == S_ST) && (rnd_r == RoundW'(Rounds));
    end
  end

  // datapath; after the final round k_r carries the folded chaining value
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (req.start) begin
        k_r <= cv;
        m_r <= req.msg;
        for (int i = 0; i < 8; i++) s_r[i] <= req.msg[i] ^ cv[i];
      end
      S_KEY: k_r <= k_lane;
      S_ST: begin
        if (rnd_r == RoundW'(Rounds)) begin
          for (int i = 0; i < 8; i++) k_r[i] <= cv[i] ^ s_lane[i] ^ m_r[i];
        end else begin
          s_r <= s_lane;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ design/whp_checker.sv @@
// port checker for the whirlpool hash core, bound to the top level
module whp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);
  // no input item is taken while a digest is being shown
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input taken during digest output");
  // last flag marks the eighth word only
  a_lastw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last word flag wrong");
  // index steps after each taken item but the last word
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest index did not advance");
  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("stalled digest item changed");
endmodule

bind whirlpool_hash_core whp_checker u_chk (.clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .word_index(out_ch.word_index), .last_word(out_ch.last_word));
